/* rtl/core/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AST_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

/* rtl/core/cphe_pkg.sv */
package cphe_pkg;

	localparam int POINTS_DEF = 64;
	localparam int CHANNELS   = 6;
	localparam int FRAC       = 16;
	localparam int ONE_Q16    = 65536;
	localparam int TWO_PI_Q16 = 411775;

	// Request opcodes.
	localparam logic [1:0] OP_WRCH  = 2'd0;
	localparam logic [1:0] OP_WRKEY = 2'd1;
	localparam logic [1:0] OP_START = 2'd2;
	localparam logic [1:0] OP_TICK  = 2'd3;

	// Configuration register indexes.
	localparam logic [0:0] REG_POINT_COUNT = 1'b0;
	localparam logic [0:0] REG_BLEND_OUT   = 1'b1;

	typedef struct packed {
		logic [1:0]         op;
		logic [5:0]         index;
		logic [2:0]         channel;
		logic signed [31:0] value;
		logic signed [31:0] slope;
		logic [31:0]        dt;
	} req_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [31:0] yaw;
		logic signed [31:0] pitch;
		logic signed [31:0] roll;
		logic [16:0]        fade;
		logic               finished;
	} rsp_t;

	typedef enum logic [4:0] {
		DP_NONE, DP_ACCEPT, DP_FIN, DP_WALK, DP_T1, DP_DIV, DP_FSET, DP_FEND,
		DP_RDA, DP_RDB, DP_MA, DP_MB, DP_CO, DP_H1, DP_H2, DP_H3, DP_H4, DP_H5,
		DP_H6, DP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic fin;
		logic walk_more;
		logic chan_last;
		logic out_free;
	} st_t;

endpackage

/* rtl/core/cphe_ram.sv */
module cphe_ram #(
	parameter int W = 32,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/core/cphe_ctrl.sv */
module cphe_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  cphe_pkg::st_t  st,
	output cphe_pkg::cmd_t cmd
);

	localparam int CW = $clog2(cphe_pkg::FRAC);

	typedef enum logic [19:0] {
		S_IDLE = 20'h00001, S_FIN  = 20'h00002, S_WALK = 20'h00004, S_T1   = 20'h00008,
		S_FDIV = 20'h00010, S_FSET = 20'h00020, S_GDIV = 20'h00040, S_FEND = 20'h00080,
		S_RDA  = 20'h00100, S_RDB  = 20'h00200, S_MA   = 20'h00400, S_MB   = 20'h00800,
		S_CO   = 20'h01000, S_H1   = 20'h02000, S_H2   = 20'h04000, S_H3   = 20'h08000,
		S_H4   = 20'h10000, S_H5   = 20'h20000, S_H6   = 20'h40000, S_OUT  = 20'h80000
	} state_t;

	state_t state_q, state_nxt;
	logic [CW-1:0] cnt_q;
	logic div_end;

	assign div_end   = (cnt_q == CW'(cphe_pkg::FRAC - 1));
	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		state_nxt = state_q;
		cmd.op    = cphe_pkg::DP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.op = cphe_pkg::DP_ACCEPT;
					if (st.is_tick) state_nxt = S_FIN;
				end
			end
			S_FIN: begin
				cmd.op    = cphe_pkg::DP_FIN;
				state_nxt = st.fin ? S_OUT : S_WALK;
			end
			S_WALK: begin
				cmd.op = cphe_pkg::DP_WALK;
				if (!st.walk_more) state_nxt = S_T1;
			end
			S_T1: begin
				cmd.op    = cphe_pkg::DP_T1;
				state_nxt = S_FDIV;
			end
			S_FDIV: begin
				cmd.op = cphe_pkg::DP_DIV;
				if (div_end) state_nxt = S_FSET;
			end
			S_FSET: begin
				cmd.op    = cphe_pkg::DP_FSET;
				state_nxt = S_GDIV;
			end
			S_GDIV: begin
				cmd.op = cphe_pkg::DP_DIV;
				if (div_end) state_nxt = S_FEND;
			end
			S_FEND: begin
				cmd.op    = cphe_pkg::DP_FEND;
				state_nxt = S_RDA;
			end
			S_RDA: begin
				cmd.op    = cphe_pkg::DP_RDA;
				state_nxt = S_RDB;
			end
			S_RDB: begin
				cmd.op    = cphe_pkg::DP_RDB;
				state_nxt = S_MA;
			end
			S_MA: begin
				cmd.op    = cphe_pkg::DP_MA;
				state_nxt = S_MB;
			end
			S_MB: begin
				cmd.op    = cphe_pkg::DP_MB;
				state_nxt = S_CO;
			end
			S_CO: begin
				cmd.op    = cphe_pkg::DP_CO;
				state_nxt = S_H1;
			end
			S_H1: begin
				cmd.op    = cphe_pkg::DP_H1;
				state_nxt = S_H2;
			end
			S_H2: begin
				cmd.op    = cphe_pkg::DP_H2;
				state_nxt = S_H3;
			end
			S_H3: begin
				cmd.op    = cphe_pkg::DP_H3;
				state_nxt = S_H4;
			end
			S_H4: begin
				cmd.op    = cphe_pkg::DP_H4;
				state_nxt = S_H5;
			end
			S_H5: begin
				cmd.op    = cphe_pkg::DP_H5;
				state_nxt = S_H6;
			end
			S_H6: begin
				cmd.op    = cphe_pkg::DP_H6;
				state_nxt = st.chan_last ? S_OUT : S_RDA;
			end
			S_OUT: begin
				if (st.out_free) begin
					cmd.op    = cphe_pkg::DP_OUT;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == S_FDIV || state_q == S_GDIV) cnt_q <= cnt_q + CW'(1);
		end
	end

endmodule

/* rtl/core/cphe_dp.sv */
module cphe_dp #(
	parameter int POINTS = cphe_pkg::POINTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [0:0]       cfg_index,
	input  logic [31:0]      cfg_data,
	input  cphe_pkg::req_t   req,
	input  cphe_pkg::cmd_t   cmd,
	output cphe_pkg::st_t    st,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output cphe_pkg::rsp_t   rsp
);

	localparam int SW = $clog2(POINTS);
	localparam int KD = POINTS * cphe_pkg::CHANNELS;
	localparam int KW = $clog2(KD);
	localparam logic [31:0] PTS = 32'(POINTS);
	localparam int NCH = cphe_pkg::CHANNELS;

	// Configuration.
	logic [6:0]  pc_q;
	logic [31:0] bo_q;

	// Track state.
	logic signed [31:0] ct_q;
	logic [SW-1:0]      seg_q;
	logic [2:0]         ch_q;
	logic               fin_q;

	// Segment and division registers.
	logic signed [31:0] t2_q, klast_q, span_q;
	logic               f_zero_q, f_one_q, g_on_q;
	logic [32:0]        dr_q;
	logic [31:0]        dd_q;
	logic [15:0]        dq_q;
	logic [16:0]        f_q, fade_q;

	// Channel evaluation registers.
	logic signed [31:0] a_q, sa_q, sb_q, av_q;
	logic signed [32:0] b_q;
	logic signed [63:0] prod_q;
	logic signed [39:0] hq_q, hr_q, acc_q;
	logic signed [57:0] hp_q;
	logic signed [31:0] res_q [NCH];

	logic rsp_valid_q;
	cphe_pkg::rsp_t rsp_q;

	// Memories.
	logic          t_we, k_we;
	logic [SW-1:0] t_waddr, t_raddr;
	logic [KW-1:0] k_waddr, k_raddr;
	logic [31:0]   t_rdata, s_rdata, kv_rdata, ks_rdata;
	logic signed [31:0] t_rd_s;

	logic [31:0]   n_c;
	logic [SW-1:0] last_c, segc, p_c;
	logic          idx_ok, fin_c, walk_c;

	function automatic logic [KW-1:0] row_addr(input logic [SW-1:0] row, input logic [2:0] c);
		row_addr = KW'(KW'(row) * KW'(NCH) + KW'(c));
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [47:0] x);
		if (x > 48'sd2147483647) sat32 = 32'sh7fffffff;
		else if (x < -48'sd2147483648) sat32 = 32'sh80000000;
		else sat32 = x[31:0];
	endfunction

	assign t_rd_s = t_rdata;

	always_comb begin
		n_c = {25'd0, pc_q};
		if (n_c < 32'd2) n_c = 32'd2;
		if (n_c > PTS) n_c = PTS;
		last_c = SW'(n_c - 32'd1);
		segc = seg_q;
		if (segc == '0) segc = SW'(1);
		if (segc > last_c) segc = last_c;
	end

	assign p_c    = seg_q - SW'(1);
	assign idx_ok = ({26'd0, req.index} < PTS);
	assign fin_c  = (ct_q >= t_rd_s);
	assign walk_c = (seg_q < last_c) && (t_rd_s < ct_q);

	assign t_we    = (cmd.op == cphe_pkg::DP_ACCEPT) && (req.op == cphe_pkg::OP_WRKEY) && idx_ok;
	assign t_waddr = SW'(req.index);
	assign k_we    = (cmd.op == cphe_pkg::DP_ACCEPT) && (req.op == cphe_pkg::OP_WRCH) && idx_ok
		&& (req.channel < 3'(NCH));
	assign k_waddr = KW'(KW'(req.index) * KW'(NCH) + KW'(req.channel));

	always_comb begin
		unique case (cmd.op)
			cphe_pkg::DP_ACCEPT: t_raddr = last_c;
			cphe_pkg::DP_FIN:    t_raddr = segc;
			cphe_pkg::DP_WALK:   t_raddr = walk_c ? seg_q + SW'(1) : p_c;
			default:             t_raddr = p_c;
		endcase
		k_raddr = (cmd.op == cphe_pkg::DP_RDA) ? row_addr(p_c, ch_q) : row_addr(seg_q, ch_q);
	end

	cphe_ram #(.W(32), .D(POINTS)) u_time (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(req.value),
		.raddr(t_raddr), .rdata(t_rdata)
	);
	cphe_ram #(.W(32), .D(POINTS)) u_span (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(req.slope),
		.raddr(t_raddr), .rdata(s_rdata)
	);
	cphe_ram #(.W(32), .D(KD)) u_kval (
		.clk(clk), .we(k_we), .waddr(k_waddr), .wdata(req.value),
		.raddr(k_raddr), .rdata(kv_rdata)
	);
	cphe_ram #(.W(32), .D(KD)) u_kslp (
		.clk(clk), .we(k_we), .waddr(k_waddr), .wdata(req.slope),
		.raddr(k_raddr), .rdata(ks_rdata)
	);

	// Time update and factor setup arithmetic.
	logic signed [33:0] sum_c;
	logic signed [32:0] den_c, nm_c, rem_c;
	logic [32:0]        den_abs, nm_abs;
	logic [32:0]        r2_c;
	logic               ge_c;

	assign sum_c   = $signed({{2{ct_q[31]}}, ct_q}) + $signed({2'b00, req.dt});
	assign den_c   = $signed({t2_q[31], t2_q}) - $signed({t_rd_s[31], t_rd_s});
	assign nm_c    = $signed({ct_q[31], ct_q}) - $signed({t_rd_s[31], t_rd_s});
	assign rem_c   = $signed({klast_q[31], klast_q}) - $signed({ct_q[31], ct_q});
	assign den_abs = den_c[32] ? 33'(-den_c) : 33'(den_c);
	assign nm_abs  = nm_c[32] ? 33'(-nm_c) : 33'(nm_c);
	assign r2_c    = {dr_q[31:0], 1'b0};
	assign ge_c    = (r2_c >= {1'b0, dd_q});

	// Channel arithmetic.
	logic signed [35:0] a36, b36, up36, dn36;
	logic               up_c, dn_c;
	logic signed [31:0] bv_c;
	logic signed [39:0] a40, b40, av40, bv40, hps_c, ma_c;

	assign a36  = 36'(a_q);
	assign b36  = 36'($signed(b_q[31:0]));
	assign up36 = b36 + 36'sd411775;
	assign dn36 = b36 - 36'sd411775;
	assign up_c = (up36 - a36) < (a36 - b36);
	assign dn_c = (a36 - dn36) < (b36 - a36);

	assign bv_c  = sat32(48'(prod_q >>> 16));
	assign a40   = 40'(a_q);
	assign b40   = 40'(b_q);
	assign av40  = 40'(av_q);
	assign bv40  = 40'(bv_c);
	assign hps_c = 40'(hp_q >>> 16);
	assign ma_c  = (cmd.op == cphe_pkg::DP_H1) ? hq_q : acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= 7'd2;
			bo_q        <= 32'd26214;
			ct_q        <= '0;
			seg_q       <= SW'(1);
			ch_q        <= '0;
			fin_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == cphe_pkg::REG_POINT_COUNT) pc_q <= cfg_data[6:0];
				else bo_q <= cfg_data;
			end
			if (cmd.op == cphe_pkg::DP_ACCEPT) begin
				if (req.op == cphe_pkg::OP_START) begin
					ct_q  <= req.value;
					seg_q <= SW'(1);
				end else if (req.op == cphe_pkg::OP_TICK) begin
					ct_q <= (sum_c > 34'sd2147483647) ? 32'sh7fffffff : sum_c[31:0];
				end
			end
			if (cmd.op == cphe_pkg::DP_FIN) begin
				fin_q <= fin_c;
				// The pointer is only clamped on ticks that go on to evaluate.
				if (!fin_c) seg_q <= segc;
			end
			if (cmd.op == cphe_pkg::DP_WALK && walk_c) seg_q <= seg_q + SW'(1);
			if (cmd.op == cphe_pkg::DP_FEND) ch_q <= '0;
			if (cmd.op == cphe_pkg::DP_H6) ch_q <= ch_q + 3'd1;
			if (cmd.op == cphe_pkg::DP_OUT) rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			cphe_pkg::DP_FIN: klast_q <= t_rd_s;
			cphe_pkg::DP_WALK: begin
				if (!walk_c) t2_q <= t_rd_s;
			end
			cphe_pkg::DP_T1: begin
				span_q   <= s_rdata;
				f_zero_q <= (den_c == '0) || (nm_c == '0) || (den_c[32] != nm_c[32]);
				f_one_q  <= (nm_abs >= den_abs);
				dr_q     <= {1'b0, nm_abs[31:0]};
				dd_q     <= den_abs[31:0];
			end
			cphe_pkg::DP_DIV: begin
				dr_q <= ge_c ? r2_c - {1'b0, dd_q} : r2_c;
				dq_q <= {dq_q[14:0], ge_c};
			end
			cphe_pkg::DP_FSET: begin
				f_q    <= f_zero_q ? 17'd0 : (f_one_q ? 17'(cphe_pkg::ONE_Q16) : {1'b0, dq_q});
				// Remaining time is positive here, since the tick is not finished.
				g_on_q <= (bo_q != '0) && (rem_c[31:0] < bo_q);
				dr_q   <= {1'b0, rem_c[31:0]};
				dd_q   <= bo_q;
			end
			cphe_pkg::DP_FEND: begin
				fade_q <= g_on_q ? 17'(cphe_pkg::ONE_Q16) - {1'b0, dq_q} : 17'd0;
			end
			cphe_pkg::DP_RDB: begin
				a_q  <= kv_rdata;
				sa_q <= ks_rdata;
			end
			cphe_pkg::DP_MA: begin
				b_q    <= 33'($signed(kv_rdata));
				sb_q   <= ks_rdata;
				prod_q <= sa_q * span_q;
			end
			cphe_pkg::DP_MB: begin
				av_q   <= sat32(48'(prod_q >>> 16));
				prod_q <= sb_q * span_q;
				// Angle channels take the end angle one turn closer when that is nearer.
				if (ch_q >= 3'd3) begin
					if (up_c) b_q <= up36[32:0];
					else if (dn_c) b_q <= dn36[32:0];
				end
			end
			cphe_pkg::DP_CO: begin
				hq_q <= av40 + bv40 - (b40 <<< 1) + (a40 <<< 1);
				hr_q <= 40'sd3 * b40 - (av40 <<< 1) - bv40 - 40'sd3 * a40;
			end
			cphe_pkg::DP_H1, cphe_pkg::DP_H3, cphe_pkg::DP_H5: begin
				hp_q <= ma_c * $signed({1'b0, f_q});
			end
			cphe_pkg::DP_H2: acc_q <= hps_c + hr_q;
			cphe_pkg::DP_H4: acc_q <= hps_c + av40;
			cphe_pkg::DP_H6: res_q[ch_q] <= sat32(48'(hps_c) + 48'(a_q));
			cphe_pkg::DP_OUT: begin
				if (fin_q) begin
					rsp_q.pos_x <= '0;
					rsp_q.pos_y <= '0;
					rsp_q.pos_z <= '0;
					rsp_q.yaw   <= '0;
					rsp_q.pitch <= '0;
					rsp_q.roll  <= '0;
					rsp_q.fade  <= 17'(cphe_pkg::ONE_Q16);
				end else begin
					rsp_q.pos_x <= res_q[0];
					rsp_q.pos_y <= res_q[1];
					rsp_q.pos_z <= res_q[2];
					rsp_q.yaw   <= res_q[3];
					rsp_q.pitch <= res_q[4];
					rsp_q.roll  <= res_q[5];
					rsp_q.fade  <= fade_q;
				end
				rsp_q.finished <= fin_q;
			end
			default: begin
			end
		endcase
	end

	assign st.is_tick   = (req.op == cphe_pkg::OP_TICK);
	assign st.fin       = fin_c;
	assign st.walk_more = walk_c;
	assign st.chan_last = (ch_q == 3'(NCH - 1));
	assign st.out_free  = !rsp_valid_q || !rsp_stall;

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* rtl/core/camera_path_hermite_evaluator.sv */
// Write and start requests are handled on acceptance and leave the controller idle.
// A tick that ends the track goes from the finish check straight to the output state.
// Other ticks walk the segment pointer forward, then run two 16-step divisions and six
// channel passes (RDA, RDB, MA, MB, CO, H1 to H6) through one datapath.
// Requests are taken only while no tick is in work; a finished result waits in the output register.
// Reset (arst_n low) sets time 0, segment 1, point_count 2, blend_out 26214; tables stay unset.
module camera_path_hermite_evaluator #(
	parameter int POINTS = cphe_pkg::POINTS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [0:0]     cfg_index,
	input  logic [31:0]    cfg_data,
	input  logic           req_valid,
	output logic           req_stall,
	input  cphe_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output cphe_pkg::rsp_t rsp
);

	cphe_pkg::cmd_t cmd;
	cphe_pkg::st_t  st;

	cphe_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .req_valid(req_valid), .req_stall(req_stall),
		.st(st), .cmd(cmd)
	);

	cphe_dp #(.POINTS(POINTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req), .cmd(cmd), .st(st), .rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall), .rsp(rsp)
	);

endmodule

/* rtl/core/cphe_check.sv */
`include "assert_macros.svh"

module cphe_check (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input cphe_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input cphe_pkg::rsp_t rsp
);

	logic fin_ok;

	assign fin_ok = (rsp.fade == 17'd65536) && (rsp.pos_x == 32'sd0) && (rsp.pos_y == 32'sd0)
		&& (rsp.pos_z == 32'sd0) && (rsp.yaw == 32'sd0) && (rsp.pitch == 32'sd0)
		&& (rsp.roll == 32'sd0);

	`AST_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid)
	`AST_NEXT(a_rsp_stable, clk, arst_n, rsp_valid && rsp_stall, $stable(rsp))
	`AST_SAME(a_fin_vals, clk, arst_n, rsp_valid && rsp.finished, fin_ok)
	`AST_NEXT(a_tick_busy, clk, arst_n, req_valid && !req_stall && req.op == cphe_pkg::OP_TICK, req_stall)

endmodule

bind camera_path_hermite_evaluator cphe_check u_check (.*);

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

	localparam int NPTS = 64;
	localparam longint TIMEOUT_CYCLES = 2000000;

	logic           clk;
	logic           arst_n;
	logic           cfg_we;
	logic [0:0]     cfg_index;
	logic [31:0]    cfg_data;
	logic           req_valid;
	logic           req_stall;
	cphe_pkg::req_t req;
	logic           rsp_valid;
	logic           rsp_stall;
	cphe_pkg::rsp_t rsp;

	camera_path_hermite_evaluator i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	// Predictor state.
	longint  pr_count;
	longint  pr_blend;
	longint  kv [NPTS*6];
	longint  ks [NPTS*6];
	longint  kt [NPTS];
	longint  kspan [NPTS];
	longint  cur_t;
	longint  cur_seg;

	cphe_pkg::req_t pending_reqs [$];
	cphe_pkg::rsp_t expected_poses [$];
	int      errors;
	longint  cycles;
	int      ticks_sent;
	int      finished_seen;
	bit      drive_done;
	int      send_gap;
	int      sink_gap;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Floor division by 65536; arithmetic shift floors.
	function automatic longint floor16(longint x);
		return x >>> 16;
	endfunction

	function automatic longint wrap_angle(longint a, longint b);
		longint up;
		longint dn;
		up = b + cphe_pkg::TWO_PI_Q16;
		dn = b - cphe_pkg::TWO_PI_Q16;
		if (up - a < a - b) return up;
		if (a - dn < b - a) return dn;
		return b;
	endfunction

	function automatic longint hermite_eval(longint a, longint av, longint b0, longint bv,
			longint f, bit angle);
		longint b;
		longint q;
		longint r;
		longint acc;
		b = angle ? wrap_angle(a, b0) : b0;
		q = av + bv - 2*b + 2*a;
		r = 3*b - 2*av - bv - 3*a;
		acc = floor16(q*f) + r;
		acc = floor16(acc*f) + av;
		acc = floor16(acc*f) + a;
		return sat32(acc);
	endfunction

	function automatic int random_gap();
		if ($urandom_range(0, 2) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
		return $urandom_range(0, 3);
	endfunction

	task automatic queue_req(cphe_pkg::req_t r);
		pending_reqs.insert(pending_reqs.size(), r);
	endtask

	// Applies one request to the predictor; ticks queue the expected pose.
	task automatic predict_request(cphe_pkg::req_t r);
		longint n;
		longint last;
		longint seg;
		longint p;
		longint den;
		longint f;
		longint span;
		longint rem;
		longint av;
		longint bv;
		longint res [6];
		cphe_pkg::rsp_t e;
		case (r.op)
			cphe_pkg::OP_WRCH: begin
				if (r.channel < 6) begin
					kv[r.index*6 + r.channel] = longint'(r.value);
					ks[r.index*6 + r.channel] = longint'(r.slope);
				end
			end
			cphe_pkg::OP_WRKEY: begin
				kt[r.index] = longint'(r.value);
				kspan[r.index] = longint'(r.slope);
			end
			cphe_pkg::OP_START: begin
				cur_t = longint'(r.value);
				cur_seg = 1;
			end
			default: begin
				cur_t = sat32(cur_t + longint'({32'd0, r.dt}));
				n = pr_count;
				if (n < 2) n = 2;
				if (n > NPTS) n = NPTS;
				last = n - 1;
				e = '0;
				if (cur_t >= kt[last]) begin
					e.fade = 17'(cphe_pkg::ONE_Q16);
					e.finished = 1'b1;
				end else begin
					seg = cur_seg;
					if (seg < 1) seg = 1;
					if (seg > last) seg = last;
					while (seg < last && kt[seg] < cur_t) seg++;
					cur_seg = seg;
					p = seg - 1;
					den = kt[seg] - kt[p];
					f = (den == 0) ? 0 : ((cur_t - kt[p]) * cphe_pkg::ONE_Q16) / den;
					if (f < 0) f = 0;
					if (f > cphe_pkg::ONE_Q16) f = cphe_pkg::ONE_Q16;
					span = kspan[p];
					for (int c = 0; c < 6; c++) begin
						av = sat32(floor16(ks[p*6 + c] * span));
						bv = sat32(floor16(ks[seg*6 + c] * span));
						res[c] = hermite_eval(kv[p*6 + c], av, kv[seg*6 + c], bv, f, c >= 3);
					end
					e.pos_x = res[0][31:0];
					e.pos_y = res[1][31:0];
					e.pos_z = res[2][31:0];
					e.yaw   = res[3][31:0];
					e.pitch = res[4][31:0];
					e.roll  = res[5][31:0];
					rem = kt[last] - cur_t;
					if (pr_blend != 0 && rem < pr_blend) begin
						f = cphe_pkg::ONE_Q16 - (rem * cphe_pkg::ONE_Q16) / pr_blend;
						if (f > cphe_pkg::ONE_Q16) f = cphe_pkg::ONE_Q16;
						if (f < 0) f = 0;
						e.fade = f[16:0];
					end
				end
				expected_poses.insert(expected_poses.size(), e);
			end
		endcase
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		errors++;
		$display("MISMATCH %s: got %0d expected %0d", what, got, want);
	endtask

	// Driver: the predictor runs on each accepted request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				predict_request(req);
				if (req.op == cphe_pkg::OP_TICK) ticks_sent++;
				void'(pending_reqs.pop_front());
				send_gap = random_gap();
			end
			if (req_valid && req_stall) begin
			end else if (send_gap > 0) begin
				req_valid <= 1'b0;
				send_gap--;
			end else if (pending_reqs.size() != 0 && !drive_done) begin
				req_valid <= 1'b1;
				req <= pending_reqs[0];
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		cphe_pkg::rsp_t w;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_poses.size() == 0) begin
					report_mismatch("unexpected response", 0, 0);
				end else begin
					w = expected_poses.pop_front();
					if (rsp.finished) finished_seen++;
					if (rsp.pos_x !== w.pos_x) report_mismatch("pos_x", rsp.pos_x, w.pos_x);
					if (rsp.pos_y !== w.pos_y) report_mismatch("pos_y", rsp.pos_y, w.pos_y);
					if (rsp.pos_z !== w.pos_z) report_mismatch("pos_z", rsp.pos_z, w.pos_z);
					if (rsp.yaw !== w.yaw) report_mismatch("yaw", rsp.yaw, w.yaw);
					if (rsp.pitch !== w.pitch) report_mismatch("pitch", rsp.pitch, w.pitch);
					if (rsp.roll !== w.roll) report_mismatch("roll", rsp.roll, w.roll);
					if (rsp.fade !== w.fade) report_mismatch("fade", rsp.fade, w.fade);
					if (rsp.finished !== w.finished)
						report_mismatch("finished", rsp.finished, w.finished);
				end
			end
			if (sink_gap > 0) begin
				sink_gap--;
				rsp_stall <= 1'b1;
			end else begin
				sink_gap = random_gap();
				rsp_stall <= (sink_gap > 0);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > TIMEOUT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("camera_path_hermite_evaluator test failed");
			$finish;
		end
	end

	function automatic cphe_pkg::req_t make_req(logic [1:0] op, int idx, int ch, longint val,
			longint slp, longint dt);
		cphe_pkg::req_t r;
		r.op = op;
		r.index = 6'(idx);
		r.channel = 3'(ch);
		r.value = val[31:0];
		r.slope = slp[31:0];
		r.dt = dt[31:0];
		return r;
	endfunction

	task automatic write_config(logic [0:0] idx, logic [31:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == cphe_pkg::REG_POINT_COUNT) pr_count = longint'(data[6:0]);
		else pr_blend = longint'(data);
	endtask

	task automatic wait_idle();
		while (pending_reqs.size() != 0 || req_valid || expected_poses.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// Queues a full table of n keyframes with mostly increasing times.
	task automatic queue_track(int n, bit big);
		longint t;
		t = $urandom_range(0, 3) == 0 ? -longint'($urandom_range(0, 200000)) : 0;
		for (int k = 0; k < n; k++) begin
			queue_req(make_req(cphe_pkg::OP_WRKEY, k, 0, t,
				big ? longint'(int'($urandom())) : longint'($urandom_range(0, 3 << 16)), 0));
			for (int c = 0; c < 6; c++)
				queue_req(make_req(cphe_pkg::OP_WRCH, k, c,
					big ? longint'(int'($urandom())) : longint'($urandom_range(0, 1 << 20)) - (1 << 19),
					big ? longint'(int'($urandom())) : longint'($urandom_range(0, 1 << 18)) - (1 << 17), 0));
			// Mostly ordered times; now and then an equal or backward step.
			case ($urandom_range(0, 9))
				0: t = t;
				1: t = t - longint'($urandom_range(1, 30000));
				default: t = t + longint'($urandom_range(1, 200000));
			endcase
			if (t > 64'sd2147483647) t = 64'sd2147483647;
		end
	endtask

	task automatic queue_ticks(int count, longint t0);
		queue_req(make_req(cphe_pkg::OP_START, $urandom(), $urandom(), t0, $urandom(), $urandom()));
		for (int i = 0; i < count; i++)
			queue_req(make_req(cphe_pkg::OP_TICK, $urandom(), $urandom(), $urandom(), $urandom(),
				$urandom_range(0, 9) == 0 ? longint'($urandom()) : longint'($urandom_range(0, 40000))));
	endtask

	initial begin
		int n;
		errors = 0;
		cycles = 0;
		ticks_sent = 0;
		finished_seen = 0;
		drive_done = 0;
		send_gap = 0;
		sink_gap = 0;
		pr_count = 2;
		pr_blend = 26214;
		cur_t = 0;
		cur_seg = 1;
		foreach (kv[i]) begin
			kv[i] = 0;
			ks[i] = 0;
		end
		foreach (kt[i]) begin
			kt[i] = 0;
			kspan[i] = 0;
		end
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: two-point track at reset settings, extreme values, ignored channels.
		queue_track(2, 1'b0);
		queue_req(make_req(cphe_pkg::OP_WRCH, 0, 7, -64'sd2147483648, 64'sd2147483647, 0));
		queue_req(make_req(cphe_pkg::OP_WRCH, 1, 6, 64'sd2147483647, -64'sd2147483648, 0));
		queue_req(make_req(cphe_pkg::OP_START, 0, 0, -64'sd2147483648, 0, 0));
		queue_req(make_req(cphe_pkg::OP_TICK, 63, 7, 0, 0, 0));
		queue_req(make_req(cphe_pkg::OP_TICK, 0, 0, 0, 0, 64'd4294967295));
		queue_req(make_req(cphe_pkg::OP_TICK, 0, 0, 0, 0, 64'd4294967295));
		queue_req(make_req(cphe_pkg::OP_START, 0, 0, 0, 0, 0));
		queue_req(make_req(cphe_pkg::OP_TICK, 0, 0, 0, 0, 1000));
		wait_idle();

		// Extreme-value track with a zero fade window and the largest count.
		write_config(cphe_pkg::REG_BLEND_OUT, 32'd0);
		write_config(cphe_pkg::REG_POINT_COUNT, 32'd64);
		queue_track(64, 1'b1);
		queue_ticks(6, -64'sd2147483648);
		wait_idle();

		// Random phases over several settings.
		for (int ph = 0; ph < 7; ph++) begin
			case (ph % 5)
				0: n = 2;
				1: n = $urandom_range(3, 8);
				2: n = $urandom_range(9, 16);
				default: n = $urandom_range(2, 16);
			endcase
			// A count above the table size uses the full table, whose upper
			// entries still hold the earlier extreme track.
			write_config(cphe_pkg::REG_POINT_COUNT,
				ph == 3 ? 32'd0 : (ph == 6 ? 32'd127 : 32'(n)));
			if (ph == 3) n = 2;
			write_config(cphe_pkg::REG_BLEND_OUT, ph == 4 ? 32'hFFFFFFFF :
				32'($urandom_range(0, 400000)));
			queue_track(n, ph == 6);
			queue_ticks(30, $urandom_range(0, 3) == 0 ? -longint'($urandom_range(0, 100000)) : 0);
			// Shrinking the count mid-run leaves the segment pointer beyond the last point.
			if (ph == 2) begin
				wait_idle();
				write_config(cphe_pkg::REG_POINT_COUNT, 32'd2);
				for (int i = 0; i < 4; i++)
					queue_req(make_req(cphe_pkg::OP_TICK, 0, 0, 0, 0, 20000));
			end
			wait_idle();
		end
		drive_done = 1;
		repeat (300) @(posedge clk);
		$display("Covered %0d ticks over 9 keyframe tables, %0d of them at track end.",
			ticks_sent, finished_seen);
		if (errors == 0 && expected_poses.size() == 0) begin
			$display("camera_path_hermite_evaluator test passed");
		end else begin
			$display("camera_path_hermite_evaluator test failed");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/cphe_pkg.sv
rtl/core/cphe_ram.sv
rtl/core/cphe_ctrl.sv
rtl/core/cphe_dp.sv
rtl/core/camera_path_hermite_evaluator.sv
rtl/core/cphe_check.sv
test/tb_top.sv
